// ===== rtl/ptl_pkg.sv =====
// Shared register index width and register map type for the point-to-line distance block.
package ptl_pkg;

  // Configuration register index port width
  localparam int CFG_IDX_W = 3;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_X  = 3'd0,
    CFG_REF_Y  = 3'd1,
    CFG_REF_Z  = 3'd2,
    CFG_AXIS_X = 3'd3,
    CFG_AXIS_Y = 3'd4,
    CFG_AXIS_Z = 3'd5
  } cfg_idx_e;

endpackage

// ===== rtl/ptl_sqrt_cell.sv =====
// One bit step of the pipelined restoring square root.
module ptl_sqrt_cell #(
  parameter int RW  = 36,
  parameter int SW  = 18,
  parameter int BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] rem_i,
  input  logic [SW-1:0] root_i,
  output logic [RW-1:0] rem_o,
  output logic [SW-1:0] root_o
);

  logic [RW-1:0] trial;

  // (root + 2^BIT)^2 - root^2
  assign trial = (RW'(root_i) << (BIT + 1)) + (RW'(1) << (2 * BIT));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rem_i >= trial) begin
        rem_o  <= rem_i - trial;
        root_o <= root_i | (SW'(1) << BIT);
      end else begin
        rem_o  <= rem_i;
        root_o <= root_i;
      end
    end
  end

endmodule

// ===== rtl/ptl_div_cell.sv =====
// One quotient bit step of the pipelined restoring divider.
module ptl_div_cell #(
  parameter int QW  = 56,
  parameter int QBW = 15,
  parameter int BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [QW-1:0]  rem_i,
  input  logic [QW-1:0]  den_i,
  input  logic [QBW-1:0] q_i,
  output logic [QW-1:0]  rem_o,
  output logic [QW-1:0]  den_o,
  output logic [QBW-1:0] q_o
);

  logic [QW-1:0] shifted;

  assign shifted = den_i << BIT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      if (rem_i >= shifted) begin
        rem_o <= rem_i - shifted;
        q_o   <= q_i | (QBW'(1) << BIT);
      end else begin
        rem_o <= rem_i;
        q_o   <= q_i;
      end
    end
  end

endmodule

// ===== rtl/point_to_line_distance_angles_top.sv =====
// Pipeline from the input transfer to the result on m_axis; its depth follows COORD_BITS and
// DIR_FRAC_BITS through the square root and divider bit cells.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears the pipeline valid bits and loads the register defaults
// (reference vertex 0, primary axis +z).
module point_to_line_distance_angles_top #(
  parameter int COORD_BITS    = 17,
  parameter int DIR_FRAC_BITS = 14,
  localparam int STW = ((3 * COORD_BITS + 3 * (DIR_FRAC_BITS + 2) + 7) / 8) * 8,
  localparam int OTW = ((2 * (COORD_BITS + 1) + COORD_BITS + 2
                         + 2 * (DIR_FRAC_BITS + 2) + 7) / 8) * 8,
  localparam int CFGW = (COORD_BITS > DIR_FRAC_BITS + 2) ? COORD_BITS : DIR_FRAC_BITS + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [ptl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFGW-1:0]               cfg_data_i,
  // candidate stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [STW-1:0]                s_axis_tdata,  // pt_x, pt_y, pt_z, alt_dir_x/y/z
  input  logic [0:0]                    s_axis_tuser,  // tagged_req
  input  logic                          s_axis_tlast,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OTW-1:0]                m_axis_tdata,  // dist_total, dist_long,
                                                       // dist_trans, cos_primary, cos_alt
  output logic [1:0]                    m_axis_tuser,  // valid_res, zero_dist_err
  output logic                          m_axis_tlast
);
  import ptl_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int F     = DIR_FRAC_BITS;
  localparam int DRW   = F + 2;
  localparam int DFW   = CW + 1;
  localparam int PW    = DFW + DRW;
  localparam int DOTW  = PW + 2;
  localparam int MW    = DOTW;
  localparam int RW    = 2 * DFW + 2;
  localparam int SW    = RW / 2;
  localparam int RTW   = SW + 1;
  localparam int DISTW = CW + 1;
  localparam int LB    = CW + 2;
  localparam int NW    = MW + 1;
  localparam int LMW   = RTW + F + 1;
  localparam int QW    = (NW > LMW) ? NW : LMW;
  localparam int QBW   = F + 1;
  localparam int LAT   = 11 + SW + F;

  typedef struct packed {
    logic                 tag;
    logic                 last;
    logic                 err;
    logic                 neg_a;
    logic                 neg_b;
    logic signed [LB-1:0] lng;
    logic [MW-1:0]        mag_a;
    logic [MW-1:0]        mag_b;
  } sq_sb_t;

  typedef struct packed {
    logic                 tag;
    logic                 last;
    logic                 err;
    logic                 neg_a;
    logic                 neg_b;
    logic                 sat_a;
    logic                 sat_b;
    logic signed [LB-1:0] lng;
    logic [DISTW-1:0]     dtot;
    logic [DISTW-1:0]     trans;
  } dv_sb_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [CW-1:0]  ref_q  [3];
  logic signed [DRW-1:0] axis_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q[0]  <= '0;
      ref_q[1]  <= '0;
      ref_q[2]  <= '0;
      axis_q[0] <= '0;
      axis_q[1] <= '0;
      axis_q[2] <= DRW'(1) << F;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_REF_X:  ref_q[0]  <= cfg_data_i[CW-1:0];
        CFG_REF_Y:  ref_q[1]  <= cfg_data_i[CW-1:0];
        CFG_REF_Z:  ref_q[2]  <= cfg_data_i[CW-1:0];
        CFG_AXIS_X: axis_q[0] <= cfg_data_i[DRW-1:0];
        CFG_AXIS_Y: axis_q[1] <= cfg_data_i[DRW-1:0];
        CFG_AXIS_Z: axis_q[2] <= cfg_data_i[DRW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together when the output slot frees
  logic [LAT-1:0] vld_q;
  logic           en;
  logic           s_fire;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign s_fire        = s_axis_tvalid && en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_fire};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: offset from the reference vertex
  logic signed [DFW-1:0] d_q [3];
  logic signed [DRW-1:0] b_q [3];
  logic                  tag0_q, last0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= $signed({s_axis_tdata[i*CW + CW - 1], s_axis_tdata[i*CW +: CW]})
                - $signed({ref_q[i][CW-1], ref_q[i]});
        b_q[i] <= s_axis_tdata[3*CW + i*DRW +: DRW];
      end
      tag0_q  <= s_axis_tuser[0];
      last0_q <= s_axis_tlast;
    end
  end

  // Stage 1: squares and axis products
  logic [2*DFW-1:0]     sq_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic                 tag1_q, last1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= d_q[i] * d_q[i];
        pa_q[i] <= d_q[i] * axis_q[i];
        pb_q[i] <= d_q[i] * b_q[i];
      end
      tag1_q  <= tag0_q;
      last1_q <= last0_q;
    end
  end

  // Stage 2: sums
  logic [RW-1:0]          d2_q;
  logic signed [DOTW-1:0] dota_q, dotb_q;
  logic                   tag2_q, last2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q   <= RW'(sq_q[0]) + RW'(sq_q[1]) + RW'(sq_q[2]);
      dota_q <= DOTW'(pa_q[0]) + DOTW'(pa_q[1]) + DOTW'(pa_q[2]);
      dotb_q <= DOTW'(pb_q[0]) + DOTW'(pb_q[1]) + DOTW'(pb_q[2]);
      tag2_q  <= tag1_q;
      last2_q <= last1_q;
    end
  end

  // Stage 3: rounded, saturated projection and magnitudes
  logic [MW-1:0] mag_a, mag_b;
  logic [NW-1:0] l_raw, l_sh, l_pos, l_neg;
  logic [LB-1:0] l_mag;

  assign mag_a = dota_q[DOTW-1] ? MW'(-dota_q) : MW'(dota_q);
  assign mag_b = dotb_q[DOTW-1] ? MW'(-dotb_q) : MW'(dotb_q);
  assign l_raw = NW'(mag_a) + (NW'(1) << (F - 1));
  assign l_sh  = l_raw >> F;
  assign l_pos = (NW'(1) << (LB - 1)) - NW'(1);
  assign l_neg = NW'(1) << (LB - 1);

  always_comb begin
    if (dota_q[DOTW-1]) begin
      l_mag = (l_sh > l_neg) ? l_neg[LB-1:0] : l_sh[LB-1:0];
    end else begin
      l_mag = (l_sh > l_pos) ? l_pos[LB-1:0] : l_sh[LB-1:0];
    end
  end

  logic [RW-1:0] d2_s3_q;
  logic [LB-1:0] lmag_q;
  sq_sb_t        sb3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_s3_q     <= d2_q;
      lmag_q      <= l_mag;
      sb3_q.tag   <= tag2_q;
      sb3_q.last  <= last2_q;
      sb3_q.err   <= (d2_q == '0);
      sb3_q.neg_a <= dota_q[DOTW-1];
      sb3_q.neg_b <= dotb_q[DOTW-1];
      sb3_q.lng   <= dota_q[DOTW-1] ? -l_mag : l_mag;
      sb3_q.mag_a <= mag_a;
      sb3_q.mag_b <= mag_b;
    end
  end

  // Stage 4: square of the projection
  logic [RW-1:0] d2_s4_q, l2_q;
  sq_sb_t        sb4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_s4_q <= d2_s3_q;
      l2_q    <= RW'(lmag_q * lmag_q);
      sb4_q   <= sb3_q;
    end
  end

  // Stage 5: transverse radicand, clamped at zero, enters the root cells
  logic [RW-1:0] rd_rem [SW+1];
  logic [SW-1:0] rd_root [SW+1];
  logic [RW-1:0] rt_rem [SW+1];
  logic [SW-1:0] rt_root [SW+1];
  logic [RW-1:0] rd0_q, rt0_q;
  sq_sb_t        sqsb_q [SW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd0_q     <= d2_s4_q;
      rt0_q     <= (d2_s4_q > l2_q) ? d2_s4_q - l2_q : '0;
      sqsb_q[0] <= sb4_q;
      for (int k = 0; k < SW; k++) begin
        sqsb_q[k+1] <= sqsb_q[k];
      end
    end
  end

  assign rd_rem[0]  = rd0_q;
  assign rt_rem[0]  = rt0_q;
  assign rd_root[0] = '0;
  assign rt_root[0] = '0;

  // Square root cell chain, most significant root bit first
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    ptl_sqrt_cell #(.RW(RW), .SW(SW), .BIT(SW - 1 - k)) u_dist (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rd_rem[k]),
      .root_i (rd_root[k]),
      .rem_o  (rd_rem[k+1]),
      .root_o (rd_root[k+1])
    );
    ptl_sqrt_cell #(.RW(RW), .SW(SW), .BIT(SW - 1 - k)) u_trans (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rt_rem[k]),
      .root_i (rt_root[k]),
      .rem_o  (rt_rem[k+1]),
      .root_o (rt_root[k+1])
    );
  end

  // Round to nearest: add one when the remainder exceeds the root
  logic [RTW-1:0] rnd_dist_q, rnd_trans_q;
  sq_sb_t         sbr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rnd_dist_q  <= RTW'(rd_root[SW]) + RTW'(rd_rem[SW] > RW'(rd_root[SW]));
      rnd_trans_q <= RTW'(rt_root[SW]) + RTW'(rt_rem[SW] > RW'(rt_root[SW]));
      sbr_q       <= sqsb_q[SW];
    end
  end

  // Divider setup: rounding numerators, saturation limit, field clamps
  localparam logic [RTW-1:0] DIST_MAX = RTW'((RTW'(1) << DISTW) - RTW'(1));

  logic [NW-1:0]  num_a_q, num_b_q;
  logic [LMW-1:0] lim_q;
  logic [RTW-1:0] den_q;
  dv_sb_t         sbp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_a_q     <= NW'(sbr_q.mag_a) + NW'(rnd_dist_q >> 1);
      num_b_q     <= NW'(sbr_q.mag_b) + NW'(rnd_dist_q >> 1);
      lim_q       <= (LMW'(rnd_dist_q) << F) + LMW'(rnd_dist_q);
      den_q       <= rnd_dist_q;
      sbp_q.tag   <= sbr_q.tag;
      sbp_q.last  <= sbr_q.last;
      sbp_q.err   <= sbr_q.err;
      sbp_q.neg_a <= sbr_q.neg_a;
      sbp_q.neg_b <= sbr_q.neg_b;
      sbp_q.sat_a <= 1'b0;
      sbp_q.sat_b <= 1'b0;
      sbp_q.lng   <= sbr_q.lng;
      sbp_q.dtot  <= (rnd_dist_q > DIST_MAX) ? DIST_MAX[DISTW-1:0]
                                             : rnd_dist_q[DISTW-1:0];
      sbp_q.trans <= (rnd_trans_q > DIST_MAX) ? DIST_MAX[DISTW-1:0]
                                              : rnd_trans_q[DISTW-1:0];
    end
  end

  // Saturation check, then the quotient cells
  logic [QW-1:0]  da_rem [QBW+1];
  logic [QW-1:0]  da_den [QBW+1];
  logic [QBW-1:0] da_quo [QBW+1];
  logic [QW-1:0]  db_rem [QBW+1];
  logic [QW-1:0]  db_den [QBW+1];
  logic [QBW-1:0] db_quo [QBW+1];
  logic [QW-1:0]  na0_q, nb0_q, den0_q;
  dv_sb_t         dvsb_q [QBW+1];
  dv_sb_t         sbs;

  always_comb begin
    sbs       = sbp_q;
    sbs.sat_a = QW'(num_a_q) >= QW'(lim_q);
    sbs.sat_b = QW'(num_b_q) >= QW'(lim_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na0_q     <= QW'(num_a_q);
      nb0_q     <= QW'(num_b_q);
      den0_q    <= QW'(den_q);
      dvsb_q[0] <= sbs;
      for (int k = 0; k < QBW; k++) begin
        dvsb_q[k+1] <= dvsb_q[k];
      end
    end
  end

  assign da_rem[0] = na0_q;
  assign db_rem[0] = nb0_q;
  assign da_den[0] = den0_q;
  assign db_den[0] = den0_q;
  assign da_quo[0] = '0;
  assign db_quo[0] = '0;

  for (genvar k = 0; k < QBW; k++) begin : g_div
    ptl_div_cell #(.QW(QW), .QBW(QBW), .BIT(QBW - 1 - k)) u_cos_a (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (da_rem[k]),
      .den_i (da_den[k]),
      .q_i   (da_quo[k]),
      .rem_o (da_rem[k+1]),
      .den_o (da_den[k+1]),
      .q_o   (da_quo[k+1])
    );
    ptl_div_cell #(.QW(QW), .QBW(QBW), .BIT(QBW - 1 - k)) u_cos_b (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (db_rem[k]),
      .den_i (db_den[k]),
      .q_i   (db_quo[k]),
      .rem_o (db_rem[k+1]),
      .den_o (db_den[k+1]),
      .q_o   (db_quo[k+1])
    );
  end

  // Output register: signs, saturation, zero-distance and untagged forcing
  dv_sb_t                fin;
  logic [QBW-1:0]        cmag_a, cmag_b;
  logic signed [DRW-1:0] cos_a, cos_b;
  logic                  zero_out;

  assign fin      = dvsb_q[QBW];
  assign cmag_a   = fin.sat_a ? (QBW'(1) << F) : da_quo[QBW];
  assign cmag_b   = fin.sat_b ? (QBW'(1) << F) : db_quo[QBW];
  assign cos_a    = fin.neg_a ? -$signed({1'b0, cmag_a}) : $signed({1'b0, cmag_a});
  assign cos_b    = fin.neg_b ? -$signed({1'b0, cmag_b}) : $signed({1'b0, cmag_b});
  assign zero_out = !fin.tag || fin.err;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero_out) begin
        m_axis_tdata <= '0;
      end else begin
        m_axis_tdata <= OTW'({cos_b, cos_a, fin.trans, fin.lng, fin.dtot});
      end
      m_axis_tuser <= {fin.tag && fin.err, fin.tag};
      m_axis_tlast <= fin.last;
    end
  end

endmodule

// ===== rtl/ptl_checker.sv =====
// Port-level checks for the point-to-line distance block, bound to the top level.
module ptl_checker #(
  parameter int COORD_BITS    = 17,
  parameter int DIR_FRAC_BITS = 14,
  localparam int OTW = ((2 * (COORD_BITS + 1) + COORD_BITS + 2
                         + 2 * (DIR_FRAC_BITS + 2) + 7) / 8) * 8
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [OTW-1:0]                m_axis_tdata,
  input logic [1:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Input is taken whenever the output slot is free or being emptied
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");

  // An untagged candidate reports nothing
  a_untagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("untagged result carries data");

  // Zero distance forces all distances and cosines to zero
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && m_axis_tuser[0])
    else $error("zero distance result carries data");

endmodule

bind point_to_line_distance_angles_top ptl_checker #(
  .COORD_BITS    (COORD_BITS),
  .DIR_FRAC_BITS (DIR_FRAC_BITS)
) u_ptl_checker (.*);
